FILE: hdl/sbusd_pkg.sv
// ----------------------------------------------------------------------------
// sbusd_pkg
// Shared constants and types of the frame decoder: frame geometry,
// configuration set, command and switch codes and the decoded result.
// ----------------------------------------------------------------------------
package sbusd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int BUFFER_BYTES = 50;

    localparam int COUNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W   = $clog2(FRAME_BYTES);
    localparam int RAW_W   = 11;
    localparam int STICK_W = 12;
    localparam int SW_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam int CHAN_FIRST_BIT = 8;
    localparam int STREAM_BITS    = 8 * FRAME_BYTES + 24;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_POS_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_POS_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_POS_HIGH = 3'd4;

    localparam logic [RAW_W-1:0] RST_CENTER_OFFSET  = 11'd1024;
    localparam logic [RAW_W-1:0] RST_ERROR_LIMIT    = 11'd700;
    localparam logic [RAW_W-1:0] RST_TWO_POS_THR    = 11'd1024;
    localparam logic [RAW_W-1:0] RST_THREE_POS_LOW  = 11'd600;
    localparam logic [RAW_W-1:0] RST_THREE_POS_HIGH = 11'd1400;

    localparam logic [SW_W-1:0] SW_LOW  = 2'd0;
    localparam logic [SW_W-1:0] SW_MID  = 2'd1;
    localparam logic [SW_W-1:0] SW_HIGH = 2'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    typedef struct packed {
        logic [RAW_W-1:0] center_offset;
        logic [RAW_W-1:0] error_limit;
        logic [RAW_W-1:0] two_pos_threshold;
        logic [RAW_W-1:0] three_pos_low;
        logic [RAW_W-1:0] three_pos_high;
    } cfg_t;

    typedef struct packed {
        logic signed [STICK_W-1:0] stick_one;
        logic signed [STICK_W-1:0] stick_two;
        logic signed [STICK_W-1:0] stick_three;
        logic signed [STICK_W-1:0] stick_four;
        logic signed [STICK_W-1:0] aux_nine;
        logic signed [STICK_W-1:0] aux_ten;
        logic [SW_W-1:0]           switch_a;
        logic [SW_W-1:0]           switch_b;
        logic [SW_W-1:0]           switch_c;
        logic [SW_W-1:0]           switch_d;
        logic                      data_error;
    } result_t;

endpackage

FILE: hdl/sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core
// Collects received bytes into a frame store and, on a line idle event that
// closes a frame of the expected length, decodes it into one result.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, command, rx_byte     | sink
//   out     | out_valid, out_stall, stick_*, aux_*,    | source
//           | switch_a..switch_d, data_error           |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink
//
// One request per cycle while not stalled; a decoded result is in the output
// register in the cycle after its idle request is taken, the decode being
// one combinational pass over the frame store. Byte requests are always taken;
// an idle request stalls only while a previous result is held by out_stall.
// Reset clears the byte count and output valid; config takes its defaults.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [7:0]                            rx_byte,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sbusd_pkg::STICK_W-1:0]  stick_one,
    output logic signed [sbusd_pkg::STICK_W-1:0]  stick_two,
    output logic signed [sbusd_pkg::STICK_W-1:0]  stick_three,
    output logic signed [sbusd_pkg::STICK_W-1:0]  stick_four,
    output logic signed [sbusd_pkg::STICK_W-1:0]  aux_nine,
    output logic signed [sbusd_pkg::STICK_W-1:0]  aux_ten,
    output logic [sbusd_pkg::SW_W-1:0]            switch_a,
    output logic [sbusd_pkg::SW_W-1:0]            switch_b,
    output logic [sbusd_pkg::SW_W-1:0]            switch_c,
    output logic [sbusd_pkg::SW_W-1:0]            switch_d,
    output logic                                  data_error,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sbusd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sbusd_pkg::RAW_W-1:0]           cfg_data
);

    sbusd_pkg::cfg_t                   cfg_reg;
    logic [sbusd_pkg::COUNT_W-1:0]     count_reg;
    logic [sbusd_pkg::COUNT_W-1:0]     count_next;
    logic [7:0]                        store_reg [sbusd_pkg::FRAME_BYTES];
    logic                              out_valid_reg;
    sbusd_pkg::result_t                result_reg;
    sbusd_pkg::result_t                result_next;

    logic in_acc;
    logic byte_acc;
    logic idle_acc;
    logic frame_ok;
    logic store_wr;

    assign cfg_ready = 1'b1;
    assign in_stall  = (command == sbusd_pkg::CMD_IDLE) & out_valid_reg & out_stall;
    assign in_acc    = in_valid & ~in_stall;
    assign byte_acc  = in_acc & (command == sbusd_pkg::CMD_BYTE);
    assign idle_acc  = in_acc & (command == sbusd_pkg::CMD_IDLE);
    assign frame_ok  = count_reg == sbusd_pkg::COUNT_W'(sbusd_pkg::FRAME_BYTES);
    assign store_wr  = byte_acc & (count_reg < sbusd_pkg::COUNT_W'(sbusd_pkg::FRAME_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_offset     <= sbusd_pkg::RST_CENTER_OFFSET;
            cfg_reg.error_limit       <= sbusd_pkg::RST_ERROR_LIMIT;
            cfg_reg.two_pos_threshold <= sbusd_pkg::RST_TWO_POS_THR;
            cfg_reg.three_pos_low     <= sbusd_pkg::RST_THREE_POS_LOW;
            cfg_reg.three_pos_high    <= sbusd_pkg::RST_THREE_POS_HIGH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sbusd_pkg::REG_CENTER_OFFSET:  cfg_reg.center_offset     <= cfg_data;
                sbusd_pkg::REG_ERROR_LIMIT:    cfg_reg.error_limit       <= cfg_data;
                sbusd_pkg::REG_TWO_POS_THR:    cfg_reg.two_pos_threshold <= cfg_data;
                sbusd_pkg::REG_THREE_POS_LOW:  cfg_reg.three_pos_low     <= cfg_data;
                sbusd_pkg::REG_THREE_POS_HIGH: cfg_reg.three_pos_high    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (idle_acc)
            count_next = '0;
        else if (byte_acc && count_reg < sbusd_pkg::COUNT_W'(sbusd_pkg::BUFFER_BYTES))
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
            store_reg[count_reg[sbusd_pkg::IDX_W-1:0]] <= rx_byte;
    end

    sbusd_decode u_decode
    (
        .frame  (store_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (idle_acc && frame_ok)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (idle_acc && frame_ok)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign stick_one   = result_reg.stick_one;
    assign stick_two   = result_reg.stick_two;
    assign stick_three = result_reg.stick_three;
    assign stick_four  = result_reg.stick_four;
    assign aux_nine    = result_reg.aux_nine;
    assign aux_ten     = result_reg.aux_ten;
    assign switch_a    = result_reg.switch_a;
    assign switch_b    = result_reg.switch_b;
    assign switch_c    = result_reg.switch_c;
    assign switch_d    = result_reg.switch_d;
    assign data_error  = result_reg.data_error;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sbusd_pkg::COUNT_W'(sbusd_pkg::BUFFER_BYTES))
        else $error("byte count above buffer size");

    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        idle_acc |=> count_reg == '0)
        else $error("byte count not cleared by idle");

    a_byte_counts: assert property (@(posedge clk) disable iff (!rst_n)
        byte_acc && count_reg < sbusd_pkg::COUNT_W'(sbusd_pkg::BUFFER_BYTES)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("byte count did not advance");

    a_bad_len_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        idle_acc && !frame_ok && !out_stall |=> !out_valid_reg)
        else $error("result from a frame of wrong length");

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.data_error |->
        result_reg.stick_one == '0 && result_reg.aux_nine == '0)
        else $error("sticks not zeroed on range error");

endmodule

FILE: hdl/sbusd_decode.sv
// ----------------------------------------------------------------------------
// sbusd_decode
// Unpacks the ten 11-bit channels of a stored frame and maps them to
// centered sticks, switch positions and the range error flag.
// ----------------------------------------------------------------------------
module sbusd_decode
(
    input  logic [7:0]            frame [sbusd_pkg::FRAME_BYTES],
    input  sbusd_pkg::cfg_t       cfg,
    output sbusd_pkg::result_t    result
);

    logic [sbusd_pkg::STREAM_BITS-1:0]  stream;
    logic [sbusd_pkg::RAW_W-1:0]        raw [10];
    logic signed [sbusd_pkg::STICK_W-1:0] cen [10];
    logic [sbusd_pkg::STICK_W-1:0]      mag [4];
    logic [3:0]                         over;
    logic                               err;

    always_comb
    begin
        stream = '0;
        for (int i = 0; i < sbusd_pkg::FRAME_BYTES; i++)
        begin
            stream[8*i +: 8] = frame[i];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 10; k++)
        begin
            raw[k] = stream[sbusd_pkg::CHAN_FIRST_BIT + sbusd_pkg::RAW_W*k +: sbusd_pkg::RAW_W];
            cen[k] = $signed({1'b0, raw[k]}) - $signed({1'b0, cfg.center_offset});
        end
        for (int k = 0; k < 4; k++)
        begin
            mag[k]  = cen[k][sbusd_pkg::STICK_W-1] ? (-cen[k]) : cen[k];
            over[k] = mag[k] > {1'b0, cfg.error_limit};
        end
        err = |over;
    end

    function automatic logic [sbusd_pkg::SW_W-1:0] two_pos(
        input logic [sbusd_pkg::RAW_W-1:0] r,
        input logic [sbusd_pkg::RAW_W-1:0] thr);
        return (r >= thr) ? sbusd_pkg::SW_HIGH : sbusd_pkg::SW_LOW;
    endfunction

    function automatic logic [sbusd_pkg::SW_W-1:0] three_pos(
        input logic [sbusd_pkg::RAW_W-1:0] r,
        input logic [sbusd_pkg::RAW_W-1:0] lo,
        input logic [sbusd_pkg::RAW_W-1:0] hi);
        logic [sbusd_pkg::SW_W-1:0] s;
        if (r < lo)
            s = sbusd_pkg::SW_LOW;
        else if (r < hi)
            s = sbusd_pkg::SW_MID;
        else
            s = sbusd_pkg::SW_HIGH;
        return s;
    endfunction

    always_comb
    begin
        result.stick_one   = err ? '0 : cen[0];
        result.stick_two   = err ? '0 : cen[1];
        result.stick_three = err ? '0 : cen[2];
        result.stick_four  = err ? '0 : cen[3];
        result.aux_nine    = err ? '0 : cen[8];
        result.aux_ten     = cen[9];
        result.switch_a    = two_pos(raw[4], cfg.two_pos_threshold);
        result.switch_b    = three_pos(raw[5], cfg.three_pos_low, cfg.three_pos_high);
        result.switch_c    = three_pos(raw[6], cfg.three_pos_low, cfg.three_pos_high);
        result.switch_d    = two_pos(raw[7], cfg.two_pos_threshold);
        result.data_error  = err;
    end

endmodule
